>>> hw/rtl/apsp_pkg.sv
// Package for the all-pairs shortest path block: field widths, codes, FSM states.
// Depends on nothing; used by all_pairs_shortest_path.
`timescale 1ns / 1ps

package apsp_pkg;

  localparam int unsigned VERTEX_W    = 3;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned DIST_W      = 32;
  localparam int unsigned VCOUNT_W    = 4;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [DIST_W-1:0]   NO_EDGE      = 32'd999999;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CP_RD,
    ST_CP_WR,
    ST_RX_RD,
    ST_RX_SUM,
    ST_RX_UPD,
    ST_DG_RD,
    ST_DG_CHK,
    ST_NEG,
    ST_EM_RD,
    ST_EM_LD
  } state_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_STEP,
    IDX_DIAG
  } idx_op_e;

endpackage

>>> hw/rtl/apsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module apsp_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/all_pairs_shortest_path.sv
// All-pairs shortest path (Floyd-Warshall) over a stored edge-weight matrix.
// Depends on apsp_pkg and apsp_ram.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: command, source, target, weight
//  m_axis    out  tvalid/tready          tdata: row, column, distance; tuser; tlast
//  cfg       in   cfg_valid/cfg_ready    cfg_data: vertex_count
//
// Write and clear beats are accepted in idle. A run walks the copy, relax,
// diagonal scan and emit phases in turn (a negative diagonal ends it with a
// single negative-cycle beat instead of the emit), the single shared add/compare
// unit stepping one matrix entry at a time; output stalls hold the run.
// Edge weights reset to diagonal 0, others 999999, through per-entry valid bits;
// no clearing pass. s_axis and cfg are ready only between items.
`timescale 1ns / 1ps

module all_pairs_shortest_path #(
  parameter int unsigned MAX_VERTICES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [1:0] command, [4:2] source_vertex, [7:5] target_vertex, [24:8] edge_weight
  input  logic [apsp_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [2:0] row_vertex, [5:3] column_vertex, [37:6] path_distance
  output logic [apsp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // [0] unreachable, [1] negative_cycle
  output logic [apsp_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,
  output logic                                m_axis_tlast_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [apsp_pkg::VCOUNT_W-1:0]       cfg_data_i
);

  import apsp_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_VERTICES);
  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CMP_W = VERTEX_W + 1;

  state_e state_q, state_d;
  idx_op_e idx_op;

  logic [VCOUNT_W-1:0] vcount_q;
  logic [CW-1:0]       n_eff;
  logic [IW-1:0]       nm1;
  logic [IW-1:0]       i_q, j_q, k_q;
  logic                ij_last, all_last;

  logic                s_acc, cfg_acc;
  cmd_e                in_cmd;
  logic [VERTEX_W-1:0] in_src, in_tgt;
  logic [WEIGHT_W-1:0] in_weight;
  logic                in_range;

  logic [DEPTH-1:0]    ew_vld_q;
  logic                ew_vld_rd_q;
  logic                ew_we, ew_clr;
  logic [AW-1:0]       ew_waddr;
  logic [DIST_W-1:0]   ew_rdata;

  logic                wd_we;
  logic [AW-1:0]       wd_waddr;
  logic [DIST_W-1:0]   wd_wdata;
  logic [AW-1:0]       rd_addr_a, rd_addr_b;
  logic [DIST_W-1:0]   rd_a, rd_b;
  logic [DIST_W-1:0]   sum_q, sum_d;

  logic                out_free, out_load, out_neg;
  logic                m_valid_q;
  logic [VERTEX_W-1:0] m_row_q, m_col_q;
  logic [DIST_W-1:0]   m_dist_q;
  logic                m_unreach_q, m_negcyc_q, m_last_q;

  // effective vertex count: 0 acts as 1, above the built maximum saturates
  always_comb begin
    if (vcount_q == '0) begin
      n_eff = CW'(1);
    end else if (vcount_q > VCOUNT_W'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vcount_q);
    end
  end

  assign nm1      = IW'(n_eff - CW'(1));
  assign ij_last  = (i_q == nm1) && (j_q == nm1);
  assign all_last = ij_last && (k_q == nm1);

  assign in_cmd    = cmd_e'(s_axis_tdata_i[1:0]);
  assign in_src    = s_axis_tdata_i[4:2];
  assign in_tgt    = s_axis_tdata_i[7:5];
  assign in_weight = s_axis_tdata_i[24:8];
  assign in_range  = ({1'b0, in_src} < CMP_W'(n_eff)) && ({1'b0, in_tgt} < CMP_W'(n_eff));

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign sum_d    = rd_a + rd_b;
  assign ew_waddr = {in_src[IW-1:0], in_tgt[IW-1:0]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc && in_cmd == CMD_RUN) state_d = ST_CP_RD;
      end
      ST_CP_RD:  state_d = ST_CP_WR;
      ST_CP_WR:  state_d = ij_last ? ST_RX_RD : ST_CP_RD;
      ST_RX_RD:  state_d = ST_RX_SUM;
      ST_RX_SUM: state_d = ST_RX_UPD;
      ST_RX_UPD: state_d = all_last ? ST_DG_RD : ST_RX_RD;
      ST_DG_RD:  state_d = ST_DG_CHK;
      ST_DG_CHK: begin
        if (rd_a[DIST_W-1]) begin
          state_d = ST_NEG;
        end else if (i_q == nm1) begin
          state_d = ST_EM_RD;
        end else begin
          state_d = ST_DG_RD;
        end
      end
      ST_NEG: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_EM_RD: begin
        if (out_free) state_d = ST_EM_LD;
      end
      ST_EM_LD:  state_d = ij_last ? ST_IDLE : ST_EM_RD;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    cfg_ready_o     = 1'b0;
    ew_we           = 1'b0;
    ew_clr          = 1'b0;
    wd_we           = 1'b0;
    wd_waddr        = {i_q, j_q};
    wd_wdata        = sum_q;
    rd_addr_a       = {i_q, j_q};
    rd_addr_b       = {k_q, j_q};
    idx_op          = IDX_HOLD;
    out_load        = 1'b0;
    out_neg         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cfg_ready_o     = 1'b1;
        ew_clr          = cfg_acc || (s_acc && in_cmd == CMD_CLEAR);
        ew_we           = s_acc && in_cmd == CMD_WRITE && in_range;
        idx_op          = IDX_CLR;
      end
      ST_CP_WR: begin
        wd_we = 1'b1;
        if (ew_vld_rd_q) begin
          wd_wdata = ew_rdata;
        end else begin
          wd_wdata = (i_q == j_q) ? '0 : NO_EDGE;
        end
        idx_op = ij_last ? IDX_CLR : IDX_STEP;
      end
      ST_RX_RD: begin
        rd_addr_a = {i_q, k_q};
      end
      ST_RX_UPD: begin
        wd_we  = $signed(sum_q) < $signed(rd_a);
        idx_op = all_last ? IDX_CLR : IDX_STEP;
      end
      ST_DG_RD: begin
        rd_addr_a = {i_q, i_q};
      end
      ST_DG_CHK: begin
        if (!rd_a[DIST_W-1]) idx_op = (i_q == nm1) ? IDX_CLR : IDX_DIAG;
      end
      ST_NEG: begin
        out_load = out_free;
        out_neg  = 1'b1;
      end
      ST_EM_LD: begin
        out_load = 1'b1;
        idx_op   = IDX_STEP;
      end
      ST_CP_RD, ST_RX_SUM, ST_EM_RD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      vcount_q <= VCOUNT_RESET;
      ew_vld_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) vcount_q <= cfg_data_i;
      if (ew_clr) begin
        ew_vld_q <= '0;
      end else if (ew_we) begin
        ew_vld_q[ew_waddr] <= 1'b1;
      end
      case (idx_op)
        IDX_CLR: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
        end
        IDX_STEP: begin
          if (j_q == nm1) begin
            j_q <= '0;
            if (i_q == nm1) begin
              i_q <= '0;
              k_q <= (k_q == nm1) ? '0 : k_q + IW'(1);
            end else begin
              i_q <= i_q + IW'(1);
            end
          end else begin
            j_q <= j_q + IW'(1);
          end
        end
        IDX_DIAG: i_q <= i_q + IW'(1);
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ew_vld_rd_q <= ew_vld_q[{i_q, j_q}];
    sum_q       <= sum_d;
    if (out_load) begin
      m_row_q     <= out_neg ? '0 : VERTEX_W'(i_q);
      m_col_q     <= out_neg ? '0 : VERTEX_W'(j_q);
      m_dist_q    <= out_neg ? '0 : rd_a;
      m_unreach_q <= !out_neg && (rd_a == NO_EDGE);
      m_negcyc_q  <= out_neg;
      m_last_q    <= out_neg || ij_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - 2 * VERTEX_W - DIST_W)'(0), m_dist_q, m_col_q, m_row_q};
  assign m_axis_tuser_o  = {m_negcyc_q, m_unreach_q};
  assign m_axis_tlast_o  = m_last_q;

  apsp_ram #(
    .DATA_W (DIST_W),
    .DEPTH  (DEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ew_we),
    .waddr_i (ew_waddr),
    .wdata_i ({{(DIST_W - WEIGHT_W){in_weight[WEIGHT_W-1]}}, in_weight}),
    .raddr_i ({i_q, j_q}),
    .rdata_o (ew_rdata)
  );

  // working matrix kept twice so two entries can be read per cycle
  apsp_ram #(
    .DATA_W (DIST_W),
    .DEPTH  (DEPTH)
  ) u_dist_ram_a (
    .clk_i   (clk_i),
    .we_i    (wd_we),
    .waddr_i (wd_waddr),
    .wdata_i (wd_wdata),
    .raddr_i (rd_addr_a),
    .rdata_o (rd_a)
  );

  apsp_ram #(
    .DATA_W (DIST_W),
    .DEPTH  (DEPTH)
  ) u_dist_ram_b (
    .clk_i   (clk_i),
    .we_i    (wd_we),
    .waddr_i (wd_waddr),
    .wdata_i (wd_wdata),
    .raddr_i (rd_addr_b),
    .rdata_o (rd_b)
  );

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over an untaken beat");

  a_neg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> m_axis_tlast_o)
    else $error("negative cycle beat without tlast");

  a_unreach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[1]) |->
      (m_axis_tuser_o[0] == (m_dist_q == NO_EDGE)))
    else $error("unreachable flag disagrees with distance");

  a_wd_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wd_we |-> (state_q == ST_CP_WR || state_q == ST_RX_UPD))
    else $error("working matrix written outside copy or relax");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && in_cmd == CMD_RUN) |=> (!s_axis_tready_o && !cfg_ready_o))
    else $error("ready while a run is in progress");

endmodule
